// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers; ASSERT_OFF removes them all.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_ALWAYS(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed");

`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

`else

`define ASSERT_ALWAYS(lbl, clk, rst, expr)

`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons)

`endif

`endif

// ===== rtl/core/odo7_pkg.sv =====
// ----------------------------------------------------------------------------
// Odometer readout package
// Types, constants and helper functions shared by the readout modules.
// ----------------------------------------------------------------------------
`default_nettype none

package odo7_pkg;

   localparam int READING_BITS = 24;
   localparam int STEP_BITS    = 6;
   localparam int NUM_STAGES   = (READING_BITS + STEP_BITS - 1) / STEP_BITS;
   localparam int PAD_BITS     = NUM_STAGES * STEP_BITS;
   localparam int DISP_DIGITS  = 7;
   localparam int BCD_BITS     = 4 * DISP_DIGITS;
   localparam int SEG_BITS     = 7;
   localparam int ICON_BITS    = 8;
   localparam int Q_DEPTH      = 2;
   localparam int Q_PTR_BITS   = $clog2(Q_DEPTH);
   localparam int Q_CNT_BITS   = $clog2(Q_DEPTH + 1);

   localparam logic [READING_BITS-1:0] ODO_LIMIT = READING_BITS'(9999999);

   localparam logic [ICON_BITS-1:0] ICON_ODO     = 8'h01;
   localparam logic [ICON_BITS-1:0] ICON_TRIP    = 8'h02;
   localparam logic [ICON_BITS-1:0] ICON_POINT   = 8'h04;
   localparam logic [ICON_BITS-1:0] ICON_KM      = 8'h08;
   localparam logic [ICON_BITS-1:0] ICON_MILE    = 8'h10;
   localparam logic [ICON_BITS-1:0] ICON_VOLT    = 8'h40;
   localparam logic [ICON_BITS-1:0] ICON_SERVICE = 8'h80;

   typedef enum logic [1:0] {
      DISPLAY_ODOMETER = 2'd0,
      DISPLAY_TRIP     = 2'd1,
      DISPLAY_SERVICE  = 2'd2,
      DISPLAY_BATTERY  = 2'd3
   } mode_type;

   typedef struct packed {
      logic [1:0]              display_mode;
      logic [READING_BITS-1:0] reading;
   } req_type;

   typedef struct packed {
      logic [SEG_BITS-1:0]  digit_five;
      logic [SEG_BITS-1:0]  digit_four;
      logic [SEG_BITS-1:0]  digit_three;
      logic [SEG_BITS-1:0]  digit_two;
      logic [SEG_BITS-1:0]  digit_one;
      logic [SEG_BITS-1:0]  digit_zero;
      logic [ICON_BITS-1:0] icon_bits;
   } rsp_type;

   typedef struct packed {
      mode_type                mode;
      logic [READING_BITS-1:0] value;
      logic [ICON_BITS-1:0]    icons;
   } item_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } slot_type;

   typedef struct packed {
      logic                 valid;
      mode_type             mode;
      logic [ICON_BITS-1:0] icons;
      logic [BCD_BITS-1:0]  bcd;
   } conv_type;

   // Runs STEP_BITS shift-and-add-3 steps, most significant input bit first.
   function automatic logic [BCD_BITS-1:0] dd_stage(input logic [BCD_BITS-1:0] bcd_in,
                                                    input logic [STEP_BITS-1:0] bits_in);
      logic [BCD_BITS-1:0] acc;
      acc = bcd_in;
      for (int j = 0; j < STEP_BITS; j++) begin
         for (int k = 0; k < DISP_DIGITS; k++) begin
            if (acc[4*k +: 4] >= 4'd5) begin
               acc[4*k +: 4] = acc[4*k +: 4] + 4'd3;
            end
         end
         acc = {acc[BCD_BITS-2:0], bits_in[STEP_BITS-1-j]};
      end
      return acc;
   endfunction

   function automatic logic [SEG_BITS-1:0] seg_glyph(input logic [3:0] code);
      logic [SEG_BITS-1:0] seg;
      case (code)
         4'd0:    seg = 7'h7E;
         4'd1:    seg = 7'h30;
         4'd2:    seg = 7'h6D;
         4'd3:    seg = 7'h79;
         4'd4:    seg = 7'h33;
         4'd5:    seg = 7'h5B;
         4'd6:    seg = 7'h5F;
         4'd7:    seg = 7'h70;
         4'd8:    seg = 7'h7F;
         4'd9:    seg = 7'h7B;
         default: seg = 7'h00;
      endcase
      return seg;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/odo7_front.sv =====
// ----------------------------------------------------------------------------
// Odometer readout front end
// Accepts transactions, holds the unit register, saturates odometer readings
// and selects the icon byte.
// ----------------------------------------------------------------------------
`default_nettype none

module odo7_front (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire odo7_pkg::req_type req_data,
   input  wire logic             csr_valid,
   output logic                  csr_ready,
   input  wire logic             csr_wdata,
   input  wire logic             q_full,
   output odo7_pkg::slot_type    push
);

   logic                unit_ff;
   logic                unit_in;
   logic                valid_ff;
   logic                valid_in;
   odo7_pkg::item_type  item_ff;
   odo7_pkg::item_type  item_in;
   odo7_pkg::mode_type  mode;
   logic                accept;
   logic                pushed;
   logic [odo7_pkg::ICON_BITS-1:0] unit_icon;

   assign csr_ready = 1'b1;
   assign pushed    = valid_ff && !q_full;
   assign busy      = valid_ff && q_full;
   assign accept    = start && !busy;
   assign mode      = odo7_pkg::mode_type'(req_data.display_mode);
   assign unit_icon = unit_ff ? odo7_pkg::ICON_MILE : odo7_pkg::ICON_KM;

   assign unit_in  = (csr_valid && csr_ready) ? csr_wdata : unit_ff;
   assign valid_in = accept || (valid_ff && !pushed);

   always_comb begin
      item_in       = item_ff;
      if (accept) begin
         item_in.mode  = mode;
         item_in.value = req_data.reading;
         case (mode)
            odo7_pkg::DISPLAY_ODOMETER: begin
               if (req_data.reading > odo7_pkg::ODO_LIMIT) begin
                  item_in.value = odo7_pkg::ODO_LIMIT;
               end
               item_in.icons = odo7_pkg::ICON_ODO | unit_icon;
            end
            odo7_pkg::DISPLAY_TRIP: begin
               item_in.icons = odo7_pkg::ICON_TRIP | odo7_pkg::ICON_POINT | unit_icon;
            end
            odo7_pkg::DISPLAY_SERVICE: begin
               item_in.icons = odo7_pkg::ICON_SERVICE | odo7_pkg::ICON_POINT | unit_icon;
            end
            odo7_pkg::DISPLAY_BATTERY: begin
               item_in.icons = odo7_pkg::ICON_VOLT | odo7_pkg::ICON_POINT;
            end
            default: begin
               item_in.icons = '0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         unit_ff  <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         unit_ff  <= unit_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   assign push.valid = valid_ff;
   assign push.item  = item_ff;

endmodule

`default_nettype wire

// ===== rtl/core/odo7_queue.sv =====
// ----------------------------------------------------------------------------
// Odometer readout queue
// Two-entry queue between the front end and the conversion pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module odo7_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire odo7_pkg::slot_type push,
   output logic                   q_full,
   output odo7_pkg::slot_type     head
);

   odo7_pkg::item_type                mem_ff [odo7_pkg::Q_DEPTH];
   logic [odo7_pkg::Q_PTR_BITS-1:0]   wr_ptr_ff;
   logic [odo7_pkg::Q_PTR_BITS-1:0]   wr_ptr_in;
   logic [odo7_pkg::Q_PTR_BITS-1:0]   rd_ptr_ff;
   logic [odo7_pkg::Q_PTR_BITS-1:0]   rd_ptr_in;
   logic [odo7_pkg::Q_CNT_BITS-1:0]   count_ff;
   logic [odo7_pkg::Q_CNT_BITS-1:0]   count_in;
   logic                              do_push;
   logic                              do_pop;

   assign q_full  = (count_ff == odo7_pkg::Q_CNT_BITS'(odo7_pkg::Q_DEPTH));
   assign do_push = push.valid && !q_full;
   assign do_pop  = (count_ff != '0);

   assign wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
   assign rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;

   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!do_push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push.item;
      end
   end

   assign head.valid = do_pop;
   assign head.item  = mem_ff[rd_ptr_ff];

endmodule

`default_nettype wire

// ===== rtl/core/odo7_conv.sv =====
// ----------------------------------------------------------------------------
// Odometer readout binary to BCD pipeline
// Shift-and-add-3 conversion, a fixed group of input bits per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module odo7_conv (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire odo7_pkg::slot_type head,
   output odo7_pkg::conv_type     conv
);

   typedef struct packed {
      logic                          valid;
      odo7_pkg::mode_type            mode;
      logic [odo7_pkg::ICON_BITS-1:0] icons;
      logic [odo7_pkg::PAD_BITS-1:0] bin;
      logic [odo7_pkg::BCD_BITS-1:0] bcd;
   } stage_type;

   stage_type stage_ff  [odo7_pkg::NUM_STAGES];
   stage_type stage_in  [odo7_pkg::NUM_STAGES];
   stage_type stage_src [odo7_pkg::NUM_STAGES];

   always_comb begin
      stage_src[0].valid = head.valid;
      stage_src[0].mode  = head.item.mode;
      stage_src[0].icons = head.item.icons;
      stage_src[0].bin   = odo7_pkg::PAD_BITS'(head.item.value);
      stage_src[0].bcd   = '0;
      for (int k = 1; k < odo7_pkg::NUM_STAGES; k++) begin
         stage_src[k] = stage_ff[k-1];
      end
      for (int k = 0; k < odo7_pkg::NUM_STAGES; k++) begin
         stage_in[k]     = stage_src[k];
         stage_in[k].bcd = odo7_pkg::dd_stage(stage_src[k].bcd,
            stage_src[k].bin[odo7_pkg::PAD_BITS-1 -: odo7_pkg::STEP_BITS]);
         stage_in[k].bin = stage_src[k].bin << odo7_pkg::STEP_BITS;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < odo7_pkg::NUM_STAGES; k++) begin
            stage_ff[k].valid <= 1'b0;
         end
      end else begin
         for (int k = 0; k < odo7_pkg::NUM_STAGES; k++) begin
            stage_ff[k] <= stage_in[k];
         end
      end
   end

   assign conv.valid = stage_ff[odo7_pkg::NUM_STAGES-1].valid;
   assign conv.mode  = stage_ff[odo7_pkg::NUM_STAGES-1].mode;
   assign conv.icons = stage_ff[odo7_pkg::NUM_STAGES-1].icons;
   assign conv.bcd   = stage_ff[odo7_pkg::NUM_STAGES-1].bcd;

endmodule

`default_nettype wire

// ===== rtl/core/odo7_format.sv =====
// ----------------------------------------------------------------------------
// Odometer readout formatter
// Places decimal digits by mode, blanks leading zeros and drives the
// registered segment patterns.
// ----------------------------------------------------------------------------
`default_nettype none

module odo7_format (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire odo7_pkg::conv_type conv,
   output logic                   rsp_valid,
   output odo7_pkg::rsp_type      rsp_data
);

   logic [3:0]         d [6];
   logic [3:0]         b [odo7_pkg::DISP_DIGITS];
   logic [5:1]         blank;
   logic               valid_ff;
   logic               valid_in;
   odo7_pkg::rsp_type  data_ff;
   odo7_pkg::rsp_type  data_in;

   always_comb begin
      for (int k = 0; k < odo7_pkg::DISP_DIGITS; k++) begin
         b[k] = conv.bcd[4*k +: 4];
      end
      for (int k = 0; k < 6; k++) begin
         d[k] = 4'd0;
      end
      case (conv.mode)
         odo7_pkg::DISPLAY_ODOMETER: begin
            for (int k = 0; k < 6; k++) begin
               d[k] = b[k+1];
            end
         end
         odo7_pkg::DISPLAY_TRIP: begin
            for (int k = 0; k < 4; k++) begin
               d[k] = b[k];
            end
         end
         odo7_pkg::DISPLAY_SERVICE: begin
            for (int k = 0; k < 5; k++) begin
               d[k] = b[k];
            end
         end
         odo7_pkg::DISPLAY_BATTERY: begin
            for (int k = 0; k < 3; k++) begin
               d[k] = b[k+1];
            end
         end
         default: begin
            d[0] = 4'd0;
         end
      endcase
   end

   always_comb begin
      blank[5] = (d[5] == 4'd0);
      blank[4] = blank[5] && (d[4] == 4'd0);
      blank[3] = blank[4] && (d[3] == 4'd0);
      blank[2] = blank[3] && (d[2] == 4'd0);
      blank[1] = blank[2] && (conv.mode == odo7_pkg::DISPLAY_ODOMETER) && (d[1] == 4'd0);
   end

   always_comb begin
      data_in.digit_five  = blank[5] ? '0 : odo7_pkg::seg_glyph(d[5]);
      data_in.digit_four  = blank[4] ? '0 : odo7_pkg::seg_glyph(d[4]);
      data_in.digit_three = blank[3] ? '0 : odo7_pkg::seg_glyph(d[3]);
      data_in.digit_two   = blank[2] ? '0 : odo7_pkg::seg_glyph(d[2]);
      data_in.digit_one   = blank[1] ? '0 : odo7_pkg::seg_glyph(d[1]);
      data_in.digit_zero  = odo7_pkg::seg_glyph(d[0]);
      data_in.icon_bits   = conv.icons;
   end

   assign valid_in = conv.valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

`default_nettype wire

// ===== rtl/core/odometer_readout_seven_segment.sv =====
// ----------------------------------------------------------------------------
// Odometer readout, seven-segment
// Turns a display mode and a binary reading into six digit patterns and an
// icon byte.
// ----------------------------------------------------------------------------
// Usage:
// A request transaction is taken at a rising edge with start high and busy
// low; req_data carries the display mode and the reading. Each result is on
// rsp_data for exactly one cycle, marked by rsp_valid, one result per request
// and in request order.
// The unit register is written through csr_valid/csr_wdata; csr_ready is
// always high. Write it only while no request is in flight.
// A request passes through the front-end register, the queue, one conversion
// stage per six reading bits and the output register, in that order.
// Throughput: one request per cycle; busy stays low because the conversion
// pipeline never stalls.
// Reset clears the unit register to kilometres and drops all transactions in
// flight. The receiver cannot stall, so no result is ever held back.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module odometer_readout_seven_segment (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire odo7_pkg::req_type  req_data,
   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire logic              csr_wdata,
   output logic                   rsp_valid,
   output odo7_pkg::rsp_type      rsp_data
);

   odo7_pkg::slot_type push;
   odo7_pkg::slot_type head;
   odo7_pkg::conv_type conv;
   logic               q_full;
   logic               volt_shown;
   logic               upper_blank;

   odo7_front u_front (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_wdata (csr_wdata),
      .q_full    (q_full),
      .push      (push)
   );

   odo7_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (push),
      .q_full (q_full),
      .head   (head)
   );

   odo7_conv u_conv (
      .clock (clock),
      .reset (reset),
      .head  (head),
      .conv  (conv)
   );

   odo7_format u_format (
      .clock     (clock),
      .reset     (reset),
      .conv      (conv),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   assign volt_shown  = rsp_valid && ((rsp_data.icon_bits & odo7_pkg::ICON_VOLT) != '0);
   assign upper_blank = (rsp_data.digit_five == '0) && (rsp_data.digit_four == '0)
                        && (rsp_data.digit_three == '0);

   `ASSERT_ALWAYS(a_never_busy, clock, reset, !busy)
   `ASSERT_IMPLIES(a_units_shown, clock, reset, rsp_valid, rsp_data.digit_zero != '0)
   `ASSERT_IMPLIES(a_volt_upper_blank, clock, reset, volt_shown, upper_blank)

endmodule

`default_nettype wire

// ===== test/tb_odometer_readout_seven_segment.sv =====
// ----------------------------------------------------------------------------
// Odometer readout testbench
// Drives display mode and reading transactions into the seven-segment readout
// with random idle bursts, switches the km/mile unit register between phases,
// and checks every readout against a predicted digit and icon pattern.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_odometer_readout_seven_segment;

   localparam int CYCLE_LIMIT   = 200000;
   localparam int SETTLE_CYCLES = 12;
   localparam int PHASE_ITEMS   = 117;
   localparam int NUM_PHASES    = 6;

   class readout_tracker;
      odo7_pkg::rsp_type expected_readouts[$];
      bit                miles;
      int                errors;

      function new();
         miles  = 1'b0;
         errors = 0;
      endfunction

      function logic [odo7_pkg::SEG_BITS-1:0] glyph_of(int unsigned digit);
         case (digit)
            0:       return 7'h7E;
            1:       return 7'h30;
            2:       return 7'h6D;
            3:       return 7'h79;
            4:       return 7'h33;
            5:       return 7'h5B;
            6:       return 7'h5F;
            7:       return 7'h70;
            8:       return 7'h7F;
            9:       return 7'h7B;
            default: return 7'h00;
         endcase
      endfunction

      function odo7_pkg::rsp_type render_readout(odo7_pkg::req_type r);
         int unsigned                    v;
         int unsigned                    d[6];
         bit                             blank[6];
         bit                             lead;
         odo7_pkg::mode_type             m;
         logic [odo7_pkg::ICON_BITS-1:0] unit_icon;
         logic [odo7_pkg::ICON_BITS-1:0] icons;
         logic [odo7_pkg::SEG_BITS-1:0]  seg[6];
         odo7_pkg::rsp_type              o;
         m = odo7_pkg::mode_type'(r.display_mode);
         v = r.reading;
         unit_icon = miles ? odo7_pkg::ICON_MILE : odo7_pkg::ICON_KM;
         for (int k = 0; k < 6; k++) begin
            d[k] = 0;
            blank[k] = 1'b0;
         end
         case (m)
            odo7_pkg::DISPLAY_ODOMETER: begin
               if (v > 9999999) begin
                  v = 9999999;
               end
               d[5] = v / 1000000;
               d[4] = (v / 100000) % 10;
               d[3] = (v / 10000) % 10;
               d[2] = (v / 1000) % 10;
               d[1] = (v / 100) % 10;
               d[0] = (v / 10) % 10;
               icons = odo7_pkg::ICON_ODO | unit_icon;
            end
            odo7_pkg::DISPLAY_TRIP: begin
               d[3] = (v / 1000) % 10;
               d[2] = (v / 100) % 10;
               d[1] = (v / 10) % 10;
               d[0] = v % 10;
               icons = odo7_pkg::ICON_TRIP | odo7_pkg::ICON_POINT | unit_icon;
            end
            odo7_pkg::DISPLAY_SERVICE: begin
               d[4] = (v / 10000) % 10;
               d[3] = (v / 1000) % 10;
               d[2] = (v / 100) % 10;
               d[1] = (v / 10) % 10;
               d[0] = v % 10;
               icons = odo7_pkg::ICON_POINT | odo7_pkg::ICON_SERVICE | unit_icon;
            end
            default: begin
               d[2] = (v / 1000) % 10;
               d[1] = (v / 100) % 10;
               d[0] = (v / 10) % 10;
               icons = odo7_pkg::ICON_POINT | odo7_pkg::ICON_VOLT;
            end
         endcase
         lead = 1'b1;
         for (int k = 5; k >= 2; k--) begin
            lead = lead && (d[k] == 0);
            blank[k] = lead;
         end
         blank[1] = lead && (m == odo7_pkg::DISPLAY_ODOMETER) && (d[1] == 0);
         for (int k = 0; k < 6; k++) begin
            seg[k] = blank[k] ? 7'h00 : glyph_of(d[k]);
         end
         o.digit_five  = seg[5];
         o.digit_four  = seg[4];
         o.digit_three = seg[3];
         o.digit_two   = seg[2];
         o.digit_one   = seg[1];
         o.digit_zero  = seg[0];
         o.icon_bits   = icons;
         return o;
      endfunction

      function void note(odo7_pkg::req_type r);
         expected_readouts.push_back(render_readout(r));
      endfunction

      function void check(odo7_pkg::rsp_type got);
         odo7_pkg::rsp_type exp;
         bit                bad;
         if (expected_readouts.size() == 0) begin
            errors++;
            if (errors <= 10) begin
               $display("unexpected readout: %h", got);
            end
            return;
         end
         exp = expected_readouts.pop_front();
         bad = 1'b0;
         bad |= (got.digit_five  !== exp.digit_five);
         bad |= (got.digit_four  !== exp.digit_four);
         bad |= (got.digit_three !== exp.digit_three);
         bad |= (got.digit_two   !== exp.digit_two);
         bad |= (got.digit_one   !== exp.digit_one);
         bad |= (got.digit_zero  !== exp.digit_zero);
         bad |= (got.icon_bits   !== exp.icon_bits);
         if (bad) begin
            errors++;
            if (errors <= 10) begin
               $display("readout mismatch: expected %h %h %h %h %h %h icons %h",
                        exp.digit_five, exp.digit_four, exp.digit_three, exp.digit_two,
                        exp.digit_one, exp.digit_zero, exp.icon_bits);
               $display("                  actual   %h %h %h %h %h %h icons %h",
                        got.digit_five, got.digit_four, got.digit_three, got.digit_two,
                        got.digit_one, got.digit_zero, got.icon_bits);
            end
         end
      endfunction

      function int pending();
         return expected_readouts.size();
      endfunction
   endclass

   logic              clock;
   logic              reset;
   logic              start;
   logic              busy;
   odo7_pkg::req_type req_data;
   logic              csr_valid;
   logic              csr_ready;
   logic              csr_wdata;
   logic              rsp_valid;
   odo7_pkg::rsp_type rsp_data;

   readout_tracker tracker = new();
   int             cycles = 0;

   odometer_readout_seven_segment u_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_wdata (csr_wdata),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("** odometer_readout_seven_segment: FAILED **");
         $finish;
      end
   end

   // Every accepted transaction on both input channels, and every readout, is observed here.
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            tracker.miles = csr_wdata;
         end
         if (start && !busy) begin
            tracker.note(req_data);
         end
         if (rsp_valid) begin
            tracker.check(rsp_data);
         end
      end
   end

   task automatic send_item(odo7_pkg::mode_type m, logic [odo7_pkg::READING_BITS-1:0] value,
                            bit may_idle);
      odo7_pkg::req_type r;
      r.display_mode = m;
      r.reading = value;
      if (may_idle && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      start <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy);
   endtask

   task automatic drain_readouts();
      start <= 1'b0;
      do @(posedge clock); while (tracker.pending() != 0);
   endtask

   task automatic write_unit(bit miles);
      drain_readouts();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_valid <= 1'b1;
      csr_wdata <= miles;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [odo7_pkg::READING_BITS-1:0] pick_reading();
      int unsigned v;
      int unsigned p;
      int          ndig;
      case ($urandom_range(0, 5))
         0: v = $urandom;
         1: v = $urandom_range(0, 99);
         2, 3: begin
            ndig = $urandom_range(1, 8);
            v = 0;
            for (int i = 0; i < ndig; i++) begin
               v = v * 10 + ($urandom_range(0, 1) ? 0 : $urandom_range(0, 9));
            end
         end
         4: v = $urandom_range(9999990, 10000010);
         default: begin
            p = 1;
            repeat ($urandom_range(1, 7)) p = p * 10;
            v = p - 1 + $urandom_range(0, 2);
         end
      endcase
      return v[odo7_pkg::READING_BITS-1:0];
   endfunction

   initial begin
      odo7_pkg::mode_type m;
      reset <= 1'b1;
      start <= 1'b0;
      req_data <= '0;
      csr_valid <= 1'b0;
      csr_wdata <= 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      write_unit(1'b0);
      send_item(odo7_pkg::DISPLAY_ODOMETER, 24'd0, 1'b1);
      send_item(odo7_pkg::DISPLAY_ODOMETER, 24'd5, 1'b1);
      send_item(odo7_pkg::DISPLAY_ODOMETER, 24'd100, 1'b1);
      send_item(odo7_pkg::DISPLAY_ODOMETER, 24'd1000000, 1'b1);
      send_item(odo7_pkg::DISPLAY_ODOMETER, 24'd9999999, 1'b1);
      send_item(odo7_pkg::DISPLAY_ODOMETER, 24'd10000000, 1'b1);
      send_item(odo7_pkg::DISPLAY_ODOMETER, 24'hFFFFFF, 1'b1);
      send_item(odo7_pkg::DISPLAY_ODOMETER, 24'd1234567, 1'b1);
      send_item(odo7_pkg::DISPLAY_ODOMETER, 24'd1002003, 1'b1);
      send_item(odo7_pkg::DISPLAY_TRIP, 24'd0, 1'b1);
      send_item(odo7_pkg::DISPLAY_TRIP, 24'd9999, 1'b1);
      send_item(odo7_pkg::DISPLAY_TRIP, 24'd10000, 1'b1);
      send_item(odo7_pkg::DISPLAY_TRIP, 24'hFFFFFF, 1'b1);
      send_item(odo7_pkg::DISPLAY_TRIP, 24'd807, 1'b1);
      send_item(odo7_pkg::DISPLAY_SERVICE, 24'd0, 1'b1);
      send_item(odo7_pkg::DISPLAY_SERVICE, 24'd99999, 1'b1);
      send_item(odo7_pkg::DISPLAY_SERVICE, 24'd100000, 1'b1);
      send_item(odo7_pkg::DISPLAY_SERVICE, 24'd20406, 1'b1);
      send_item(odo7_pkg::DISPLAY_BATTERY, 24'd0, 1'b1);
      send_item(odo7_pkg::DISPLAY_BATTERY, 24'd1234, 1'b1);
      send_item(odo7_pkg::DISPLAY_BATTERY, 24'hFFFFFF, 1'b1);
      send_item(odo7_pkg::DISPLAY_BATTERY, 24'd9, 1'b1);
      write_unit(1'b1);
      send_item(odo7_pkg::DISPLAY_ODOMETER, 24'd4321, 1'b1);
      send_item(odo7_pkg::DISPLAY_TRIP, 24'd5, 1'b1);
      send_item(odo7_pkg::DISPLAY_SERVICE, 24'd12345, 1'b1);
      send_item(odo7_pkg::DISPLAY_BATTERY, 24'd1250, 1'b1);

      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         write_unit((ph % 2) == 0);
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            if (ph == 2 && i == PHASE_ITEMS / 2) begin
               drain_readouts();
            end
            m = odo7_pkg::mode_type'($urandom_range(0, 3));
            send_item(m, pick_reading(), ph != NUM_PHASES - 1);
         end
      end

      drain_readouts();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (tracker.errors == 0 && tracker.pending() == 0) begin
         $display("** odometer_readout_seven_segment: PASSED **");
      end else begin
         $display("** odometer_readout_seven_segment: FAILED **");
      end
      $finish;
   end

endmodule

`default_nettype wire
